// ===== hw/rtl/slcd_pkg.sv =====
package slcd_pkg;

    // Field widths of the byte stream, of the result words and of the checksum.
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 17;
    localparam int SUM_W  = 16;

    // Framing constants.
    localparam logic [BYTE_W-1:0] SYNC_FIRST    = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND   = 8'h5A;
    localparam logic [IDX_W-1:0]  LEN_EXTRA     = 17'd2;
    localparam logic [IDX_W-1:0]  MIN_TOTAL     = 17'd6;
    localparam logic [IDX_W-1:0]  MAX_LEN_RESET = 17'd4096;

    // Fixed byte positions inside a frame.
    localparam logic [IDX_W-1:0] POS_SYNC_END = 17'd2;
    localparam logic [IDX_W-1:0] POS_LEN_LOW  = 17'd3;
    localparam logic [IDX_W-1:0] POS_LEN_HIGH = 17'd4;
    localparam logic [IDX_W-1:0] POS_LEN_CHK  = 17'd5;

    // Receive phase.
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC  = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    // Frame status reported with each result word.
    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_GOOD   = 2'd1,
        ST_BADSUM = 2'd2,
        ST_BADLEN = 2'd3
    } status_t;

    // One result word as held in the output queue.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              frame_end;
        status_t           status;
    } result_t;

endpackage

// ===== hw/rtl/slcd_if.sv =====
// Byte stream into the deframer.
interface slcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result words out of the deframer.
interface slcd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic [16:0] byte_index;
    logic        frame_end;
    logic [1:0]  status;

    modport source (output valid, output frame_byte, output byte_index,
                    output frame_end, output status, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input frame_end, input status, output ready);
endinterface

// ===== hw/rtl/sync_length_checksum_deframer.sv =====
// Each byte taken inside a frame, and the second sync byte, is registered as a result word
// in a three-word output queue; the output port shows the head of that queue.
// Throughput: one byte per cycle; the second sync byte yields two words, and input is held
// off only while two or more words wait in the output queue.
// Reset (rst_n low, asynchronous): hunting for sync, queue empty, maximum length 4096.
module sync_length_checksum_deframer (
    input  logic              clk,
    input  logic              rst_n,
    slcd_in_if.sink           rx,
    slcd_out_if.source        frm,
    input  logic              cfg_wr_en,
    input  logic [16:0]       cfg_wr_data
);

    localparam int QDEPTH = 3;

    slcd_pkg::phase_t                   phase_reg, phase_next;
    logic [slcd_pkg::IDX_W-1:0]         position_reg, position_next;
    logic [slcd_pkg::IDX_W-1:0]         total_reg, total_next;
    logic [slcd_pkg::BYTE_W-1:0]        len_low_reg, len_low_next;
    logic [slcd_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [slcd_pkg::BYTE_W-1:0]        check_low_reg, check_low_next;
    logic [slcd_pkg::IDX_W-1:0]         max_len_reg;

    slcd_pkg::result_t                  queue_reg [QDEPTH];
    slcd_pkg::result_t                  queue_next [QDEPTH];
    logic [1:0]                         count_reg, count_next;

    logic                               accept;
    logic                               pop;
    logic [slcd_pkg::BYTE_W-1:0]        b;
    logic [1:0]                         push_cnt;
    slcd_pkg::result_t                  res0, res1;
    logic                               frame_done;
    logic [slcd_pkg::IDX_W:0]           pos_p1, pos_p2;
    logic [slcd_pkg::SUM_W-1:0]         sum_plus_b;
    logic [slcd_pkg::SUM_W-1:0]         recv_check;
    logic [1:0]                         wpos;

    // Handshakes: take a byte only when the queue has room for two words.
    assign accept = rx.valid && rx.ready;
    assign pop    = frm.valid && frm.ready;
    assign b      = rx.rx_byte;
    assign rx.ready = (count_reg <= 2'd1);

    // Output port shows the head of the queue.
    assign frm.valid      = (count_reg != 2'd0);
    assign frm.frame_byte = queue_reg[0].frame_byte;
    assign frm.byte_index = queue_reg[0].byte_index;
    assign frm.frame_end  = queue_reg[0].frame_end;
    assign frm.status     = queue_reg[0].status;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= slcd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                slcd_pkg::PH_SYNC:
                begin
                    phase_next = (b == slcd_pkg::SYNC_SECOND) ? slcd_pkg::PH_FRAME
                                                              : slcd_pkg::PH_HUNT;
                end
                slcd_pkg::PH_FRAME:
                begin
                    phase_next = frame_done ? slcd_pkg::PH_HUNT : slcd_pkg::PH_FRAME;
                end
                default:
                begin
                    phase_next = (b == slcd_pkg::SYNC_FIRST) ? slcd_pkg::PH_SYNC
                                                             : slcd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    assign pos_p1     = {1'b0, position_reg} + 18'd1;
    assign pos_p2     = {1'b0, position_reg} + 18'd2;
    assign sum_plus_b = sum_reg + {8'd0, b};
    assign recv_check = {b, check_low_reg};

    // Frame datapath: result words and frame state updates for the accepted byte.
    always_comb
    begin
        position_next  = position_reg;
        total_next     = total_reg;
        len_low_next   = len_low_reg;
        sum_next       = sum_reg;
        check_low_next = check_low_reg;
        push_cnt       = 2'd0;
        frame_done     = 1'b0;
        res0 = '{frame_byte: b, byte_index: position_reg, frame_end: 1'b0,
                 status: slcd_pkg::ST_BUSY};
        res1 = '{frame_byte: slcd_pkg::SYNC_SECOND, byte_index: 17'd1, frame_end: 1'b0,
                 status: slcd_pkg::ST_BUSY};

        if (accept && phase_reg == slcd_pkg::PH_SYNC && b == slcd_pkg::SYNC_SECOND)
        begin
            // Header found: emit both sync bytes.
            push_cnt        = 2'd2;
            res0.frame_byte = slcd_pkg::SYNC_FIRST;
            res0.byte_index = '0;
            sum_next        = 16'(slcd_pkg::SYNC_FIRST) + 16'(slcd_pkg::SYNC_SECOND);
            position_next   = slcd_pkg::POS_SYNC_END;
            total_next      = '0;
        end
        else if (accept && phase_reg == slcd_pkg::PH_FRAME)
        begin
            push_cnt = 2'd1;
            if (position_reg < slcd_pkg::POS_LEN_HIGH)
            begin
                if (position_reg == slcd_pkg::POS_LEN_LOW)
                begin
                    len_low_next = b;
                end
                sum_next      = sum_plus_b;
                position_next = pos_p1[slcd_pkg::IDX_W-1:0];
            end
            else if (position_reg == slcd_pkg::POS_LEN_HIGH)
            begin
                total_next     = {1'b0, b, len_low_reg} + slcd_pkg::LEN_EXTRA;
                sum_next       = sum_plus_b;
                check_low_next = b;
                position_next  = slcd_pkg::POS_LEN_CHK;
            end
            else if (position_reg == slcd_pkg::POS_LEN_CHK &&
                     (total_reg > max_len_reg || total_reg < slcd_pkg::MIN_TOTAL))
            begin
                // Length out of range: abort on this byte.
                frame_done     = 1'b1;
                res0.frame_end = 1'b1;
                res0.status    = slcd_pkg::ST_BADLEN;
                position_next  = '0;
            end
            else if (position_reg == slcd_pkg::POS_LEN_CHK &&
                     total_reg == slcd_pkg::MIN_TOTAL)
            begin
                // Minimal frame: the length-high byte doubles as checksum low byte.
                frame_done     = 1'b1;
                res0.frame_end = 1'b1;
                res0.status    = (recv_check == (sum_reg - {8'd0, check_low_reg}))
                                 ? slcd_pkg::ST_GOOD : slcd_pkg::ST_BADSUM;
                position_next  = '0;
            end
            else if (pos_p1 >= {1'b0, total_reg})
            begin
                // Last byte: compare the received checksum.
                frame_done     = 1'b1;
                res0.frame_end = 1'b1;
                res0.status    = (recv_check == sum_reg) ? slcd_pkg::ST_GOOD
                                                         : slcd_pkg::ST_BADSUM;
                position_next  = '0;
            end
            else
            begin
                if (pos_p2 == {1'b0, total_reg})
                begin
                    check_low_next = b;
                end
                else
                begin
                    sum_next = sum_plus_b;
                end
                position_next = pos_p1[slcd_pkg::IDX_W-1:0];
            end
        end
    end

    // Output queue: shift out at the head, append new words behind the survivors.
    assign wpos = count_reg - {1'b0, pop};

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && i < QDEPTH - 1)
            begin
                queue_next[i] = queue_reg[i+1];
            end
            else
            begin
                queue_next[i] = queue_reg[i];
            end
            if (push_cnt != 2'd0 && wpos == 2'(i))
            begin
                queue_next[i] = res0;
            end
            if (push_cnt == 2'd2 && wpos + 2'd1 == 2'(i))
            begin
                queue_next[i] = res1;
            end
        end
        count_next = wpos + push_cnt;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slcd_pkg::PH_HUNT;
            position_reg  <= '0;
            total_reg     <= '0;
            len_low_reg   <= '0;
            sum_reg       <= '0;
            check_low_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            total_reg     <= total_next;
            len_low_reg   <= len_low_next;
            sum_reg       <= sum_next;
            check_low_reg <= check_low_next;
            count_reg     <= count_next;
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

    // A word that does not end a frame always reports a frame in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frm.valid && !frm.frame_end) |-> (frm.status == slcd_pkg::ST_BUSY))
        else $error("non-final word carries a final status");

    // The second sync byte opens a frame at position two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == slcd_pkg::PH_SYNC && b == slcd_pkg::SYNC_SECOND)
        |=> (phase_reg == slcd_pkg::PH_FRAME && position_reg == slcd_pkg::POS_SYNC_END))
        else $error("sync pair did not open a frame");

    // Any frame end sends the receiver back to hunting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_done) |=> (phase_reg == slcd_pkg::PH_HUNT && count_reg != 2'd0))
        else $error("frame end did not restart the hunt");

    // The queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'(QDEPTH)) |-> !rx.ready)
        else $error("input ready while output queue is full");

endmodule
